>>> rtl/core/arn_pkg.sv
// arn_pkg: shared types and constants for the auto range normalizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package arn_pkg;

  // default configuration
  localparam int SAMPLE_BITS_DEF  = 10;
  localparam int WINDOW_DEPTH_DEF = 8;

  // scaled output format
  localparam int                 SCALE_BITS = 14;
  localparam logic [SCALE_BITS-1:0] FULL_SCALE = 14'h3FFF;

  // dead zone is range / 128
  localparam int DEAD_SHIFT = 7;

  // input kind codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // control from the sequencer to the range tracker
  typedef struct packed {
    logic load;   // capture a sample and widen the range
    logic clear;  // restart calibration
  } range_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/arn_range.sv
// arn_range: running min/max tracker with dead-zone clamp and dividend setup
// depends on arn_pkg
`timescale 1ns / 1ps
`default_nettype none

module arn_range #(
  parameter int SAMPLE_BITS = arn_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire arn_pkg::range_ctl_t                   ctl,
  input  wire logic [SAMPLE_BITS-1:0]                sample,
  output logic                                       span_zero,
  output logic [SAMPLE_BITS-1:0]                     span,
  output logic [SAMPLE_BITS+arn_pkg::SCALE_BITS-1:0] dividend
);
  import arn_pkg::*;

  localparam int NUM_BITS = SAMPLE_BITS + SCALE_BITS;

  logic [SAMPLE_BITS-1:0] low_r, low_nxt;
  logic [SAMPLE_BITS-1:0] high_r, high_nxt;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [SAMPLE_BITS-1:0] dead;
  logic [SAMPLE_BITS-1:0] off_raw;
  logic [SAMPLE_BITS-1:0] off;

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (ctl.clear) begin
      low_nxt  = '1;
      high_nxt = '0;
    end else if (ctl.load) begin
      if (sample < low_r) low_nxt = sample;
      if (sample > high_r) high_nxt = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '1;
      high_r <= '0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
    if (ctl.load) smp_r <= sample;
  end

  // evaluated the cycle after load, from the widened range
  always_comb begin
    span      = high_r - low_r;
    span_zero = (span == '0);
    dead      = span >> DEAD_SHIFT;
    off_raw   = smp_r - low_r;
    off       = off_raw;
    if (off_raw < dead) off = '0;
    if (off > span - dead) off = span;
    // off * 16383 = (off << 14) - off
    dividend  = {off, {SCALE_BITS{1'b0}}} - NUM_BITS'(off);
  end

endmodule

`default_nettype wire

>>> rtl/core/arn_div.sv
// arn_div: serial restoring divider, one quotient bit per cycle
// depends on arn_pkg; quotient must fit in SCALE_BITS bits
`timescale 1ns / 1ps
`default_nettype none

module arn_div #(
  parameter int SAMPLE_BITS = arn_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic [SAMPLE_BITS+arn_pkg::SCALE_BITS-1:0] dividend,
  input  wire logic [SAMPLE_BITS-1:0]                divisor,
  output logic                                       busy,
  output logic [arn_pkg::SCALE_BITS-1:0]             quotient
);
  import arn_pkg::*;

  localparam int CNT_BITS = $clog2(SCALE_BITS + 1);

  logic                    busy_r;
  logic [CNT_BITS-1:0]     cnt_r;
  logic [SAMPLE_BITS-1:0]  rem_r;
  logic [SAMPLE_BITS-1:0]  div_r;
  logic [SCALE_BITS-1:0]   lo_r;
  logic [SCALE_BITS-1:0]   q_r;
  logic [SAMPLE_BITS:0]    trial;
  logic                    fits;

  // partial remainder stays below the divisor, so trial < 2 * divisor
  assign trial = {rem_r, lo_r[SCALE_BITS-1]};
  assign fits  = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_BITS'(SCALE_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) busy_r <= 1'b0;
    end
    if (start) begin
      // upper part is already below the divisor since the quotient fits
      rem_r <= dividend[SAMPLE_BITS+SCALE_BITS-1:SCALE_BITS];
      lo_r  <= dividend[SCALE_BITS-1:0];
      div_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? SAMPLE_BITS'(trial - {1'b0, div_r}) : trial[SAMPLE_BITS-1:0];
      lo_r  <= {lo_r[SCALE_BITS-2:0], 1'b0};
      q_r   <= {q_r[SCALE_BITS-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

>>> rtl/core/auto_range_normalizer_top.sv
// auto_range_normalizer_top: sequencer, stability tracking and stream ports
// depends on arn_pkg, arn_range, arn_div
`timescale 1ns / 1ps
`default_nettype none

// Normalizes raw pedal converter samples against a self-calibrating min/max
// range: the offset above the minimum is snapped to either end inside a
// range/128 dead zone, scaled as offset*16383/range and inverted; a zero range
// gives 16383. A sample transfer (tuser = 0) yields one result; a clear
// transfer (tuser = 1) restarts calibration and stability and yields none.
// The stable flag in the result's tuser goes high, and stays high until a
// clear, once the last WINDOW_DEPTH results since the clear are all equal.
// A sample passes through a setup state, the divide state, which waits for the
// divider to finish its 14 quotient bits, and a finish state; a zero range
// skips the divide state, and a clear is taken in the idle state alone.
// in_tready is low while a sample is in work, so a new sample cannot enter
// before the previous one is through; the output register lets the next
// sample enter while the previous result waits.
module auto_range_normalizer_top #(
  parameter int SAMPLE_BITS  = arn_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_DEPTH = arn_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,  // [SAMPLE_BITS-1:0] sample
  input  wire logic                              in_tuser,  // [0] kind
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [15:0]                            out_tdata, // [13:0] scaled_value
  output logic                                   out_tuser  // [0] stable
);
  import arn_pkg::*;

  localparam int RUN_BITS = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic                    zero_r;
  logic [RUN_BITS-1:0]     run_r;
  logic                    stable_r;
  logic [SCALE_BITS-1:0]   prev_r;
  logic                    out_valid_r;
  logic [SCALE_BITS-1:0]   out_value_r;
  logic                    out_stable_r;

  range_ctl_t                      rctl;
  logic                            in_xfer;
  logic                            span_zero;
  logic [SAMPLE_BITS-1:0]          span;
  logic [SAMPLE_BITS+SCALE_BITS-1:0] dividend;
  logic                            div_start;
  logic                            div_busy;
  logic [SCALE_BITS-1:0]           quotient;
  logic                            out_free;
  logic [SCALE_BITS-1:0]           scaled;
  logic [RUN_BITS-1:0]             run_nxt;
  logic                            stable_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign rctl.load  = in_xfer && (in_tuser == KIND_SAMPLE);
  assign rctl.clear = in_xfer && (in_tuser == KIND_CLEAR);
  assign div_start  = (state_r == S_PREP) && !span_zero;
  assign out_free   = !out_valid_r || out_tready;

  arn_range #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_range (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rctl),
    .sample    (in_tdata[SAMPLE_BITS-1:0]),
    .span_zero (span_zero),
    .span      (span),
    .dividend  (dividend)
  );

  arn_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // window of equal values is tracked as a run length since the last clear
  always_comb begin
    scaled = zero_r ? FULL_SCALE : (FULL_SCALE - quotient);
    if (run_r == '0 || scaled != prev_r) begin
      run_nxt = RUN_BITS'(1);
    end else if (run_r == RUN_BITS'(WINDOW_DEPTH)) begin
      run_nxt = run_r;
    end else begin
      run_nxt = run_r + 1'b1;
    end
    stable_nxt = stable_r || (run_nxt == RUN_BITS'(WINDOW_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= '0;
      stable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // the finish state reloads the output register itself
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (rctl.clear) begin
            run_r    <= '0;
            stable_r <= 1'b0;
          end else if (rctl.load) begin
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          zero_r  <= span_zero;
          state_r <= span_zero ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (!div_busy) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            prev_r       <= scaled;
            run_r        <= run_nxt;
            stable_r     <= stable_nxt;
            out_value_r  <= scaled;
            out_stable_r <= stable_nxt;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_value_r};
  assign out_tuser  = out_stable_r;

endmodule

`default_nettype wire

>>> tb/tb_auto_range_normalizer_top.sv
// tb_auto_range_normalizer_top: self-checking bench for the auto range normalizer
// predicts min/max tracking, dead zone snap, scaling and the sticky stable flag per sample
// depends on arn_pkg and auto_range_normalizer_top
`timescale 1ns / 1ps

module tb_auto_range_normalizer_top;
  import arn_pkg::*;

  localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int WINDOW_DEPTH = WINDOW_DEPTH_DEF;
  localparam int IN_W         = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 50;

  typedef struct packed {
    logic [SCALE_BITS-1:0] scaled;
    logic                  stable;
  } reading_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            in_tuser = KIND_SAMPLE;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [15:0]     out_tdata;
  logic            out_tuser;

  // bench copy of the block state
  logic [SAMPLE_BITS-1:0] cal_low;
  logic [SAMPLE_BITS-1:0] cal_high;
  logic [SCALE_BITS-1:0]  window_vals [WINDOW_DEPTH];
  int                     window_fill;
  int                     window_slot;
  logic                   stable_seen;

  reading_t expected_readings [$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       items_sent = 0;
  bit       steady = 1'b0;

  auto_range_normalizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void restart_calibration();
    cal_low     = '1;
    cal_high    = '0;
    window_fill = 0;
    window_slot = 0;
    stable_seen = 1'b0;
  endfunction

  // widen the range, snap inside the dead zone, scale, invert, then update the window
  function automatic void normalize_sample(logic [SAMPLE_BITS-1:0] smp);
    int unsigned span;
    int unsigned dead;
    int unsigned offset;
    logic [SCALE_BITS-1:0] scaled;
    bit all_same;
    reading_t r;
    if (smp < cal_low) cal_low = smp;
    if (smp > cal_high) cal_high = smp;
    span = cal_high - cal_low;
    if (span == 0) begin
      scaled = FULL_SCALE;
    end else begin
      dead   = span >> DEAD_SHIFT;
      offset = smp - cal_low;
      if (offset < dead) offset = 0;
      if (offset > span - dead) offset = span;
      scaled = FULL_SCALE - SCALE_BITS'((offset * FULL_SCALE) / span);
    end
    window_vals[window_slot] = scaled;
    window_slot = (window_slot + 1) % WINDOW_DEPTH;
    if (window_fill < WINDOW_DEPTH) window_fill++;
    if (window_fill == WINDOW_DEPTH) begin
      all_same = 1'b1;
      for (int i = 1; i < WINDOW_DEPTH; i++)
        if (window_vals[i] != window_vals[0]) all_same = 1'b0;
      if (all_same) stable_seen = 1'b1;
    end
    r.scaled = scaled;
    r.stable = stable_seen;
    expected_readings.push_back(r);
  endfunction

  task automatic send_item(input logic kind, input int smp);
    while (!steady && $urandom_range(0, 99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_W'(smp);
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (kind == KIND_CLEAR) restart_calibration();
    else normalize_sample(SAMPLE_BITS'(smp));
  endtask

  task automatic send_sample(input int smp);
    send_item(KIND_SAMPLE, smp);
  endtask

  // hold off the sender until every predicted result has been checked
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // receiver side: random backpressure and result checking
  always @(posedge clk) begin
    reading_t want;
    cycle_count <= cycle_count + 1;
    out_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 9);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_readings.size() == 0) begin
        $error("result with nothing expected: scaled_value %0d stable %0d",
               out_tdata[SCALE_BITS-1:0], out_tuser);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_tdata[SCALE_BITS-1:0] !== want.scaled) begin
          $error("scaled_value: expected %0d, actual %0d", want.scaled,
                 out_tdata[SCALE_BITS-1:0]);
          error_count++;
        end
        if (out_tuser !== want.stable) begin
          $error("stable: expected %0d, actual %0d", want.stable, out_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // first sample sets both ends, then extremes and both dead zone edges of a full range
  task automatic test_first_sample_and_extremes();
    send_sample(512);
    send_sample(0);
    send_sample(SAMPLE_MAX);
    send_sample(6);
    send_sample(SAMPLE_MAX - 6);
    send_sample(7);
    send_sample(SAMPLE_MAX - 7);
    wait_all_results();
  endtask

  // clear ignores its sample field; back-to-back clears; next sample sees zero range
  task automatic test_clear();
    send_item(KIND_CLEAR, SAMPLE_MAX);
    send_item(KIND_CLEAR, 0);
    send_sample(300);
    wait_all_results();
  endtask

  // a full window of equal values latches stable, and it stays set
  task automatic test_stable_window();
    send_item(KIND_CLEAR, 0);
    repeat (WINDOW_DEPTH) send_sample(700);
    send_sample(0);
    wait_all_results();
  endtask

  // calibration sessions with a settled hold value, mixed with raw noise
  task automatic test_random_sessions();
    int session;
    int lo;
    int hi;
    int tmp;
    int hold;
    int jit;
    int target;
    session = 0;
    target  = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      session++;
      steady = (session >= 15 && session < 35);
      if ($urandom_range(0, 99) < 75) begin
        send_item(KIND_CLEAR, $urandom_range(0, SAMPLE_MAX));
        lo = $urandom_range(0, SAMPLE_MAX);
        hi = $urandom_range(0, SAMPLE_MAX);
        if (lo > hi) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
        send_sample(lo);
        send_sample(hi);
        repeat ($urandom_range(0, 6)) send_sample($urandom_range(lo, hi));
        case ($urandom_range(0, 3))
          0: hold = lo;
          1: hold = hi;
          default: hold = $urandom_range(lo, hi);
        endcase
        repeat ($urandom_range(6, 14)) send_sample(hold);
        repeat ($urandom_range(0, 4)) begin
          jit = hold + $urandom_range(0, 8) - 4;
          if (jit < lo) jit = lo;
          if (jit > hi) jit = hi;
          send_sample(jit);
        end
      end else begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 99) < 8) send_item(KIND_CLEAR, $urandom_range(0, SAMPLE_MAX));
          else send_sample($urandom_range(0, SAMPLE_MAX));
        end
      end
      if ($urandom_range(0, 99) < 5) wait_all_results();
    end
    steady = 1'b0;
    wait_all_results();
  endtask

  initial begin
    restart_calibration();
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_sample_and_extremes();
    test_clear();
    test_stable_window();
    test_random_sessions();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/arn_pkg.sv
rtl/core/arn_range.sv
rtl/core/arn_div.sv
rtl/core/auto_range_normalizer_top.sv
tb/tb_auto_range_normalizer_top.sv
